// File: rtl/mexp_pkg.sv
// ============================================================================
// mexp_pkg
// Shared types, constants and the restoring reduction step used by the
// modular exponentiation pipeline.
// ============================================================================
package mexp_pkg;

    localparam int WORD_W       = 32;
    localparam int RED_STEPS    = WORD_W;
    localparam int EXP_BITS_DEF = 32;
    localparam int IN_DATA_W    = 3 * WORD_W;
    localparam int OUT_DATA_W   = ((WORD_W + 1 + 7) / 8) * 8;
    localparam logic [WORD_W-1:0] ONE_WORD = 32'h0000_0001;

    // One reduction lane: partial remainder and the dividend bits still to
    // shift in, most significant first.
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] low;
    } lane_t;

    typedef struct packed {
        logic              err;
        logic [WORD_W-1:0] expv;
        logic [WORD_W-1:0] modv;
        lane_t             acc;
        lane_t             pw;
    } item_t;

    // Shift in one dividend bit, subtract the modulus once if it fits.
    function automatic lane_t red_step(lane_t l, logic [WORD_W-1:0] m);
        logic [WORD_W:0] t;
        lane_t           r;
        t = {l.rem, l.low[WORD_W-1]};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        r.rem = t[WORD_W-1:0];
        r.low = {l.low[WORD_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

// File: rtl/mexp_step_cell.sv
// ============================================================================
// mexp_step_cell
// One restoring reduction step on both lanes, registered.
// ============================================================================
module mexp_step_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  mexp_pkg::item_t in_item,
    output logic            out_valid,
    output mexp_pkg::item_t out_item
);

    logic            valid_reg;
    mexp_pkg::item_t item_reg;
    mexp_pkg::item_t item_next;

    always_comb
    begin
        item_next     = in_item;
        item_next.acc = mexp_pkg::red_step(in_item.acc, in_item.modv);
        item_next.pw  = mexp_pkg::red_step(in_item.pw, in_item.modv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/mexp_mul_cell.sv
// ============================================================================
// mexp_mul_cell
// Form the two products of one exponent bit and consume that bit.
// ============================================================================
module mexp_mul_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  mexp_pkg::item_t in_item,
    output logic            out_valid,
    output mexp_pkg::item_t out_item
);

    logic                          valid_reg;
    mexp_pkg::item_t               item_reg;
    mexp_pkg::item_t               item_next;
    logic [2*mexp_pkg::WORD_W-1:0] acc_prod;
    logic [2*mexp_pkg::WORD_W-1:0] pw_prod;

    always_comb
    begin
        // A clear bit passes the accumulator through: 0:acc reduces to acc.
        if (in_item.expv[0])
        begin
            acc_prod = in_item.acc.rem * in_item.pw.rem;
        end
        else
        begin
            acc_prod = {{mexp_pkg::WORD_W{1'b0}}, in_item.acc.rem};
        end
        pw_prod = in_item.pw.rem * in_item.pw.rem;

        item_next          = in_item;
        item_next.expv     = {1'b0, in_item.expv[mexp_pkg::WORD_W-1:1]};
        item_next.acc.rem  = acc_prod[2*mexp_pkg::WORD_W-1:mexp_pkg::WORD_W];
        item_next.acc.low  = acc_prod[mexp_pkg::WORD_W-1:0];
        item_next.pw.rem   = pw_prod[2*mexp_pkg::WORD_W-1:mexp_pkg::WORD_W];
        item_next.pw.low   = pw_prod[mexp_pkg::WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/mexp_bit_cell.sv
// ============================================================================
// mexp_bit_cell
// One exponent bit: a multiply stage followed by a row of reduction steps.
// ============================================================================
module mexp_bit_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  mexp_pkg::item_t in_item,
    output logic            out_valid,
    output mexp_pkg::item_t out_item
);

    logic            valid_chain [mexp_pkg::RED_STEPS+1];
    mexp_pkg::item_t item_chain  [mexp_pkg::RED_STEPS+1];

    mexp_mul_cell u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (valid_chain[0]),
        .out_item  (item_chain[0])
    );

    for (genvar g = 0; g < mexp_pkg::RED_STEPS; g++)
    begin : g_step
        mexp_step_cell u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_chain[g]),
            .in_item   (item_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_item  (item_chain[g+1])
        );
    end

    assign out_valid = valid_chain[mexp_pkg::RED_STEPS];
    assign out_item  = item_chain[mexp_pkg::RED_STEPS];

endmodule

// File: rtl/modular_exponentiation_top.sv
// ============================================================================
// modular_exponentiation_top
// Pipelined right-to-left square-and-multiply, base^exponent mod modulus.
// ============================================================================
// Accepts one transaction per clock while the output is not held, and returns
// one result per transaction, in order. The chain is one input register,
// 32 restoring reduction cells that bring the base below the modulus, then
// one cell per exponent bit, each a 32x32 multiply stage followed by 32
// reduction cells working on the multiply and square products side by side.
// The whole chain advances together; when the output transaction is held by
// tready, every cell holds and s_axis_tready drops. A zero modulus returns
// power_result 0 with zero_modulus_error set. Exponent bits at or above
// EXP_BITS are ignored.
module modular_exponentiation_top #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // base_value [31:0], exponent [63:32], modulus [95:64]
    input  logic [mexp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // power_result [31:0], zero_modulus_error [32], zero pad [39:33]
    output logic [mexp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int W = mexp_pkg::WORD_W;

    logic            advance;
    logic            in_valid_reg;
    mexp_pkg::item_t in_item_reg;
    mexp_pkg::item_t in_item_next;

    logic            base_valid [mexp_pkg::RED_STEPS+1];
    mexp_pkg::item_t base_item  [mexp_pkg::RED_STEPS+1];
    logic            bit_valid  [EXP_BITS+1];
    mexp_pkg::item_t bit_item   [EXP_BITS+1];

    mexp_pkg::item_t last_item;
    logic [W-1:0]    power_result;

    // Advance the chain whenever the output slot is free or being drained.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // Seed both lanes: the accumulator lane reduces 1 by the modulus, the
    // power lane reduces the base.
    always_comb
    begin
        in_item_next.err      = (s_axis_tdata[3*W-1:2*W] == '0);
        in_item_next.expv     = s_axis_tdata[2*W-1:W];
        in_item_next.modv     = s_axis_tdata[3*W-1:2*W];
        in_item_next.acc.rem  = '0;
        in_item_next.acc.low  = mexp_pkg::ONE_WORD;
        in_item_next.pw.rem   = '0;
        in_item_next.pw.low   = s_axis_tdata[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_item_reg <= in_item_next;
        end
    end

    assign base_valid[0] = in_valid_reg;
    assign base_item[0]  = in_item_reg;

    // Bring the base (and the initial 1) below the modulus.
    for (genvar g = 0; g < mexp_pkg::RED_STEPS; g++)
    begin : g_base
        mexp_step_cell u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (base_valid[g]),
            .in_item   (base_item[g]),
            .out_valid (base_valid[g+1]),
            .out_item  (base_item[g+1])
        );
    end

    assign bit_valid[0] = base_valid[mexp_pkg::RED_STEPS];
    assign bit_item[0]  = base_item[mexp_pkg::RED_STEPS];

    // One cell per exponent bit, least significant first.
    for (genvar b = 0; b < EXP_BITS; b++)
    begin : g_bit
        mexp_bit_cell u_bit (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (bit_valid[b]),
            .in_item   (bit_item[b]),
            .out_valid (bit_valid[b+1]),
            .out_item  (bit_item[b+1])
        );
    end

    // The last cell's register is the output register.
    assign last_item     = bit_item[EXP_BITS];
    assign m_axis_tvalid = bit_valid[EXP_BITS];
    assign power_result  = last_item.err ? '0 : last_item.acc.rem;
    assign m_axis_tdata  = {{(mexp_pkg::OUT_DATA_W-W-1){1'b0}}, last_item.err, power_result};

    // A held output transaction stays valid.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output dropped while stalled");

    // A held output transaction keeps its data.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // The error flag always comes with a zero result.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[W] |-> m_axis_tdata[W-1:0] == '0)
        else $error("error result not zero");

    // No input is taken while the chain is held.
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted during stall");

endmodule
